[design/bdpc_pkg.sv]
// ----------------------------------------------------------------------------
// bdpc_pkg: shared types and constants for the button press classifier
// Register indexes, reset values and the per-poll result record.
// ----------------------------------------------------------------------------
package bdpc_pkg;

  localparam int unsigned CFG_INDEX_BITS = 8;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam int unsigned NOW_BITS       = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_TIME   = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_PRESS_TIME = 8'd1;

  localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_TIME_RESET   = 16'd50;
  localparam logic [CFG_DATA_BITS-1:0] LONG_PRESS_TIME_RESET = 16'd1500;

  typedef struct packed {
    logic stable_pressed;
    logic long_hold_reached;
    logic short_press;
    logic long_press;
    logic label;
  } bdpc_result_t;

endpackage

[design/bdpc_engine.sv]
// ----------------------------------------------------------------------------
// bdpc_engine: debounce and press classification state
// Holds the per-button state and updates it once per stepped poll.
// ----------------------------------------------------------------------------
module bdpc_engine
  import bdpc_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic                     raw,
  input  logic [TIME_BITS-1:0]     now,
  input  logic [CFG_DATA_BITS-1:0] debounce_time,
  input  logic [CFG_DATA_BITS-1:0] long_press_time,
  output bdpc_result_t             result
);

  logic                 debounced_level, debounced_level_next;
  logic [TIME_BITS-1:0] last_stable_time, last_stable_time_next;
  logic                 previous_level;
  logic [TIME_BITS-1:0] press_start_time, press_start_time_next;
  logic                 hold_announced, hold_announced_next;
  logic                 label_bit, label_bit_next;

  logic [TIME_BITS-1:0] since_stable;
  logic [TIME_BITS-1:0] since_press;
  logic                 debounce_done;
  logic                 hold_long;

  assign since_stable  = now - last_stable_time;
  assign since_press   = now - press_start_time;
  assign debounce_done = since_stable >= TIME_BITS'(debounce_time);
  assign hold_long     = since_press >= TIME_BITS'(long_press_time);

  always_comb begin
    debounced_level_next  = debounced_level;
    last_stable_time_next = last_stable_time;
    press_start_time_next = press_start_time;
    hold_announced_next   = hold_announced;
    label_bit_next        = label_bit;
    result                = '0;

    // debounce: refresh while raw agrees, accept a change once it has waited
    if (raw != debounced_level) begin
      if (debounce_done) begin
        debounced_level_next  = raw;
        last_stable_time_next = now;
      end
    end else begin
      last_stable_time_next = now;
    end

    if (debounced_level_next && !previous_level) begin
      press_start_time_next = now;
      hold_announced_next   = 1'b0;
    end

    if (debounced_level_next && previous_level && !hold_announced && hold_long) begin
      hold_announced_next      = 1'b1;
      result.long_hold_reached = 1'b1;
    end

    if (!debounced_level_next && previous_level) begin
      if (hold_long) begin
        result.long_press = 1'b1;
      end else begin
        label_bit_next     = !label_bit;
        result.short_press = 1'b1;
      end
    end

    result.stable_pressed = debounced_level_next;
    result.label          = label_bit_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounced_level  <= 1'b0;
      last_stable_time <= '0;
      previous_level   <= 1'b0;
      press_start_time <= '0;
      hold_announced   <= 1'b0;
      label_bit        <= 1'b0;
    end else if (step) begin
      debounced_level  <= debounced_level_next;
      last_stable_time <= last_stable_time_next;
      previous_level   <= debounced_level_next;
      press_start_time <= press_start_time_next;
      hold_announced   <= hold_announced_next;
      label_bit        <= label_bit_next;
    end
  end

endmodule

[design/button_debounce_press_classifier.sv]
// ----------------------------------------------------------------------------
// button_debounce_press_classifier: debounced button with short/long press
// Polls in, one classified result beat out per poll.
// ----------------------------------------------------------------------------
// Each input beat is one poll of a push button: the raw level and a
// free-running millisecond timestamp. Every poll yields exactly one result
// beat carrying the debounced level, three event pulses (long hold reached,
// short press released, long press released) and the label bit, which a
// short press toggles. Elapsed times are wrapping differences modulo
// 2^TIME_BITS; only the low TIME_BITS bits of now_ms count when TIME_BITS is
// below 32. A poll goes from the input register through one subtract and
// compare per timer into the result register, so the block sustains one poll
// per cycle while the result is not stalled; a poll's beat is registered in
// the input register and then in the result register, where a stall holds it.
// Configuration writes are taken at any time (cfg_ready is tied high) but
// must only be issued while no poll is in flight; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module button_debounce_press_classifier
  import bdpc_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  // poll channel
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      raw_pressed,
  input  logic [NOW_BITS-1:0]       now_ms,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      stable_pressed,
  output logic                      long_hold_reached,
  output logic                      short_press,
  output logic                      long_press,
  output logic                      label,
  // configuration write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic [CFG_DATA_BITS-1:0] debounce_time;
  logic [CFG_DATA_BITS-1:0] long_press_time;

  logic                 in_full;
  logic                 raw_q;
  logic [TIME_BITS-1:0] now_q;

  logic         advance;
  logic         step;
  bdpc_result_t step_result;
  bdpc_result_t result_q;

  // advance the pipe whenever the result register is free or being drained
  assign advance  = !out_valid || out_ready;
  assign step     = in_full && advance;
  assign in_ready = !in_full || advance;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time   <= DEBOUNCE_TIME_RESET;
      long_press_time <= LONG_PRESS_TIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEBOUNCE_TIME:   debounce_time   <= cfg_data;
        REG_LONG_PRESS_TIME: long_press_time <= cfg_data;
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // input register: hold the poll until the engine takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      raw_q <= raw_pressed;
      now_q <= TIME_BITS'(now_ms);  // zero-extend or keep the low bits
    end
  end

  bdpc_engine #(
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .raw             (raw_q),
    .now             (now_q),
    .debounce_time   (debounce_time),
    .long_press_time (long_press_time),
    .result          (step_result)
  );

  // result register: one beat per stepped poll
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_q <= step_result;
    end
  end

  assign stable_pressed    = result_q.stable_pressed;
  assign long_hold_reached = result_q.long_hold_reached;
  assign short_press       = result_q.short_press;
  assign long_press        = result_q.long_press;
  assign label             = result_q.label;

endmodule
